FILE: rtl/npa_pkg.sv
// ----------------------------------------------------------------------------
// npa_pkg
// shared codes, widths and default sizes of the node pool allocator
// ----------------------------------------------------------------------------
package npa_pkg;

   localparam int FUNC_W   = 2;
   localparam int POOL_W   = 2;
   localparam int HANDLE_W = 10;
   localparam int STATUS_W = 2;

   localparam int NUM_POOLS_DEF     = 4;
   localparam int POOL_CAPACITY_DEF = 1024;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

endpackage

FILE: rtl/npa_ram.sv
// ----------------------------------------------------------------------------
// npa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module npa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/node_pool_allocator.sv
// ----------------------------------------------------------------------------
// node_pool_allocator
// node handle allocator with independent pools, bump counter plus free stack
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_ready) takes one word per operation: allocate,
//   free or clear all pools, with a pool number and the handle to return.
//   rsp channel (rsp_valid/rsp_ready) gives exactly one word per request:
//   granted handle, status and a flag for a handle reused from the free stack.
//   a result word passes the first stage and then the output register after
//   its request is accepted; a receiver stall can hold it in either.
//   throughput: one request per cycle while rsp_ready is high. the bump and
//   stack counters live in flops and update at accept; the free stacks sit in
//   one ram with a registered read port, read as a pop is accepted.
//   a push is written at its accept edge, so a pop in the next cycle already
//   reads it and no forwarding path is needed.
//   reset: all counters return to zero and both stages empty; the stack ram
//   needs no clearing pass since only entries pushed since then are popped.
//   receiver stall: the result waits in the output register; one more
//   request is taken into the first stage, then req_ready drops.
// ----------------------------------------------------------------------------
module node_pool_allocator #(
   parameter int NUM_POOLS     = npa_pkg::NUM_POOLS_DEF,
   parameter int POOL_CAPACITY = npa_pkg::POOL_CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [npa_pkg::FUNC_W-1:0]     req_func,
   input  logic [npa_pkg::POOL_W-1:0]     req_pool_type,
   input  logic [npa_pkg::HANDLE_W-1:0]   req_freed_handle,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [npa_pkg::HANDLE_W-1:0]   rsp_granted_handle,
   output logic [npa_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_reused
);

   localparam int PW     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int PTRW   = $clog2(POOL_CAPACITY);
   localparam int CW     = $clog2(POOL_CAPACITY + 1);
   localparam int DEPTH  = NUM_POOLS * (2 ** PTRW);
   localparam int MEM_AW = $clog2(DEPTH);
   localparam int HW     = npa_pkg::HANDLE_W;
   localparam int SW     = npa_pkg::STATUS_W;

   logic [CW-1:0] bump_ff  [NUM_POOLS];
   logic [CW-1:0] bump_in  [NUM_POOLS];
   logic [CW-1:0] stack_ff [NUM_POOLS];
   logic [CW-1:0] stack_in [NUM_POOLS];

   logic          req_fire;
   logic          s1_adv;
   logic          pool_ok;
   logic [PW-1:0] pool_idx;
   logic [CW-1:0] cur_bump;
   logic [CW-1:0] cur_stack;
   logic [CW-1:0] stack_dec;

   logic          s1_valid_ff;
   logic [SW-1:0] s1_status_ff, s1_status_in;
   logic [HW-1:0] s1_granted_ff, s1_granted_in;
   logic          s1_reused_ff, s1_reused_in;

   logic          rsp_valid_ff;
   logic [SW-1:0] rsp_status_ff;
   logic [HW-1:0] rsp_granted_ff;
   logic          rsp_reused_ff;

   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [PW+PTRW-1:0]   wr_addr_full;
   logic [PW+PTRW-1:0]   rd_addr_full;
   logic [HW-1:0]        mem_rd_data;

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   assign pool_ok   = 32'(req_pool_type) < 32'(NUM_POOLS);
   assign pool_idx  = PW'(req_pool_type);
   assign cur_bump  = bump_ff[pool_idx];
   assign cur_stack = stack_ff[pool_idx];
   assign stack_dec = cur_stack - CW'(1);

   assign wr_addr_full = {pool_idx, cur_stack[PTRW-1:0]};
   assign rd_addr_full = {pool_idx, stack_dec[PTRW-1:0]};

   always_comb begin
      bump_in       = bump_ff;
      stack_in      = stack_ff;
      s1_status_in  = npa_pkg::ST_DONE;
      s1_granted_in = '0;
      s1_reused_in  = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      if (req_fire) begin
         unique case (req_func)
            npa_pkg::FUNC_ALLOC: begin
               if (!pool_ok) begin
                  s1_status_in = npa_pkg::ST_EXHAUSTED;
               end else if (cur_stack != '0) begin
                  stack_in[pool_idx] = stack_dec;
                  mem_rd_en          = 1'b1;
                  s1_reused_in       = 1'b1;
               end else if (cur_bump < CW'(POOL_CAPACITY)) begin
                  s1_granted_in     = HW'(cur_bump);
                  bump_in[pool_idx] = cur_bump + CW'(1);
               end else begin
                  s1_status_in = npa_pkg::ST_EXHAUSTED;
               end
            end
            npa_pkg::FUNC_FREE: begin
               if (!pool_ok || cur_stack >= CW'(POOL_CAPACITY)) begin
                  s1_status_in = npa_pkg::ST_OVERFLOW;
               end else begin
                  mem_wr_en          = 1'b1;
                  stack_in[pool_idx] = cur_stack + CW'(1);
               end
            end
            npa_pkg::FUNC_CLEAR: begin
               for (int p = 0; p < NUM_POOLS; p++) begin
                  bump_in[p]  = '0;
                  stack_in[p] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   npa_ram #(
      .WIDTH (HW),
      .DEPTH (DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr_full[MEM_AW-1:0]),
      .wr_data (req_freed_handle),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr_full[MEM_AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            bump_ff[p]  <= '0;
            stack_ff[p] <= '0;
         end
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bump_ff  <= bump_in;
         stack_ff <= stack_in;
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_status_ff  <= s1_status_in;
         s1_granted_ff <= s1_granted_in;
         s1_reused_ff  <= s1_reused_in;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_status_ff  <= s1_status_ff;
         rsp_granted_ff <= s1_reused_ff ? mem_rd_data : s1_granted_ff;
         rsp_reused_ff  <= s1_reused_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_handle = rsp_granted_ff;
   assign rsp_reused         = rsp_reused_ff;

   // checks
   for (genvar p = 0; p < NUM_POOLS; p++) begin : g_chk
      a_count_range: assert property (@(posedge clock) disable iff (reset)
         bump_ff[p] <= CW'(POOL_CAPACITY) && stack_ff[p] <= CW'(POOL_CAPACITY))
         else $error("pool counter beyond capacity");

      a_clear_empties: assert property (@(posedge clock) disable iff (reset)
         req_fire && req_func == npa_pkg::FUNC_CLEAR
         |=> bump_ff[p] == '0 && stack_ff[p] == '0)
         else $error("clear left a pool counter set");
   end

   a_reuse_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_reused_ff |-> rsp_status_ff == npa_pkg::ST_DONE)
      else $error("reused word with failing status");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while both stages are held");

   a_pop_read: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> !mem_wr_en && req_func == npa_pkg::FUNC_ALLOC)
      else $error("stack read outside a pop");

endmodule
